/* rtl/core/e2r_pkg.sv */
package e2r_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int IO_BITS      = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int EW           = FRAC_BITS + 2;
    localparam int PW           = 2 * EW;
    localparam int SW           = PW + 1;
    localparam int CS           = 30 - FRAC_BITS;
    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint CRND     = (CS == 0) ? 0 : (longint'(1) << (CS - 1));
    localparam longint PRND     = longint'(1) << (FRAC_BITS - 1);
    localparam logic [31:0] BAM_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;

    function automatic t_cw atan_step(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return CW'(v);
    endfunction

    function automatic logic [31:0] to_bam(input logic [IO_BITS-1:0] f);
        logic [31:0] w;
        w = {{(32-IO_BITS){1'b0}}, f} & BAM_MASK;
        return w << (32 - ANGLE_BITS);
    endfunction

    function automatic t_elem cordic_out(input t_cw v);
        t_cw r;
        r = (v + CW'(CRND)) >>> CS;
        if (r > CW'(ONE)) begin
            r = CW'(ONE);
        end else if (r < -CW'(ONE)) begin
            r = -CW'(ONE);
        end
        return EW'(r);
    endfunction

    function automatic t_elem prod_out(input t_sum v);
        t_sum r;
        r = (v + SW'(PRND)) >>> FRAC_BITS;
        if (r > SW'(ONE)) begin
            r = SW'(ONE);
        end else if (r < -SW'(ONE)) begin
            r = -SW'(ONE);
        end
        return EW'(r);
    endfunction

endpackage

/* rtl/core/euler_to_rotation_matrix_top.sv */
// Converts one yaw, pitch and roll triple per beat into a 3x3 rotation matrix in Q1.14,
// saturated to +-1.0. The datapath is a fully pipelined chain: one register stage for the
// quadrant fold, thirty CORDIC stages run side by side for the three angles, one stage that
// rounds and saturates the sines and cosines, then two multiply and round stage pairs for
// the matrix products. A new beat is taken every cycle while the output is not held off.
// When the output is held off, the whole pipeline stalls and the input ready falls in the
// same cycle.
module euler_to_rotation_matrix_top
    import e2r_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [IO_BITS-1:0] i_yaw_angle,
    input  logic signed [IO_BITS-1:0] i_pitch_angle,
    input  logic signed [IO_BITS-1:0] i_roll_angle,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [IO_BITS-1:0] o_r00,
    output logic signed [IO_BITS-1:0] o_r01,
    output logic signed [IO_BITS-1:0] o_r02,
    output logic signed [IO_BITS-1:0] o_r10,
    output logic signed [IO_BITS-1:0] o_r11,
    output logic signed [IO_BITS-1:0] o_r12,
    output logic signed [IO_BITS-1:0] o_r20,
    output logic signed [IO_BITS-1:0] o_r21,
    output logic signed [IO_BITS-1:0] o_r22
);

    localparam int NSTG = CORDIC_STEPS + 6;

    logic            en;
    logic [NSTG-1:0] r_vld;

    logic [31:0] n_ang  [3];
    logic [2:0]  n_flip;
    t_cw         n_z    [3];

    t_cw   r_x    [0:CORDIC_STEPS][3];
    t_cw   r_y    [0:CORDIC_STEPS][3];
    t_cw   r_z    [0:CORDIC_STEPS][3];
    logic [2:0] r_flip [0:CORDIC_STEPS];

    t_elem r_s [3];
    t_elem r_c [3];
    t_prod r_p [4];
    t_elem r_cx1, r_sx1, r_cy1, r_sy1, r_cz1, r_sz1;
    t_elem r_t  [3][3];
    t_elem r_cz2, r_sz2;
    t_prod r_m  [3][4];
    t_elem r_t2 [3];
    t_elem r_out [3][3];

    assign en          = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    always_comb begin
        n_ang[0] = 32'd0 - to_bam(i_pitch_angle);
        n_ang[1] = to_bam(i_yaw_angle);
        n_ang[2] = 32'd0 - to_bam(i_roll_angle);
        for (int a = 0; a < 3; a++) begin
            n_flip[a] = n_ang[a][31] ^ n_ang[a][30];
            n_z[a]    = CW'(signed'(n_flip[a] ? (n_ang[a] ^ 32'h80000000) : n_ang[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_x[0][a] <= CORDIC_GAIN;
                r_y[0][a] <= '0;
                r_z[0][a] <= n_z[a];
            end
            r_flip[0] <= n_flip;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int a = 0; a < 3; a++) begin
                    if (r_z[g][a] >= 0) begin
                        r_x[g+1][a] <= r_x[g][a] - (r_y[g][a] >>> g);
                        r_y[g+1][a] <= r_y[g][a] + (r_x[g][a] >>> g);
                        r_z[g+1][a] <= r_z[g][a] - atan_step(g);
                    end else begin
                        r_x[g+1][a] <= r_x[g][a] + (r_y[g][a] >>> g);
                        r_y[g+1][a] <= r_y[g][a] - (r_x[g][a] >>> g);
                        r_z[g+1][a] <= r_z[g][a] + atan_step(g);
                    end
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_flip[CORDIC_STEPS][a]) begin
                    r_c[a] <= cordic_out(-r_x[CORDIC_STEPS][a]);
                    r_s[a] <= cordic_out(-r_y[CORDIC_STEPS][a]);
                end else begin
                    r_c[a] <= cordic_out(r_x[CORDIC_STEPS][a]);
                    r_s[a] <= cordic_out(r_y[CORDIC_STEPS][a]);
                end
            end

            r_p[0] <= r_s[0] * r_s[1];
            r_p[1] <= r_s[0] * r_c[1];
            r_p[2] <= r_c[0] * r_s[1];
            r_p[3] <= r_c[0] * r_c[1];
            r_cx1  <= r_c[0];
            r_sx1  <= r_s[0];
            r_cy1  <= r_c[1];
            r_sy1  <= r_s[1];
            r_cz1  <= r_c[2];
            r_sz1  <= r_s[2];

            r_t[0][0] <= r_cy1;
            r_t[0][1] <= '0;
            r_t[0][2] <= -r_sy1;
            r_t[1][0] <= prod_out(SW'(r_p[0]));
            r_t[1][1] <= r_cx1;
            r_t[1][2] <= prod_out(SW'(r_p[1]));
            r_t[2][0] <= prod_out(SW'(r_p[2]));
            r_t[2][1] <= -r_sx1;
            r_t[2][2] <= prod_out(SW'(r_p[3]));
            r_cz2     <= r_cz1;
            r_sz2     <= r_sz1;

            for (int i = 0; i < 3; i++) begin
                r_m[i][0] <= r_t[i][0] * r_cz2;
                r_m[i][1] <= r_t[i][1] * r_sz2;
                r_m[i][2] <= r_t[i][0] * r_sz2;
                r_m[i][3] <= r_t[i][1] * r_cz2;
                r_t2[i]   <= r_t[i][2];
            end

            for (int i = 0; i < 3; i++) begin
                r_out[i][0] <= prod_out(SW'(r_m[i][0]) - SW'(r_m[i][1]));
                r_out[i][1] <= prod_out(SW'(r_m[i][2]) + SW'(r_m[i][3]));
                r_out[i][2] <= r_t2[i];
            end
        end
    end

    assign o_r00 = IO_BITS'(r_out[0][0]);
    assign o_r01 = IO_BITS'(r_out[0][1]);
    assign o_r02 = IO_BITS'(r_out[0][2]);
    assign o_r10 = IO_BITS'(r_out[1][0]);
    assign o_r11 = IO_BITS'(r_out[1][1]);
    assign o_r12 = IO_BITS'(r_out[1][2]);
    assign o_r20 = IO_BITS'(r_out[2][0]);
    assign o_r21 = IO_BITS'(r_out[2][1]);
    assign o_r22 = IO_BITS'(r_out[2][2]);

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result beat shown straight after reset.");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("Input beat taken while the pipeline is stalled.");

    a_elem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out[0][0] <= EW'(ONE)) && (r_out[0][0] >= -EW'(ONE))
                     && (r_out[1][1] <= EW'(ONE)) && (r_out[1][1] >= -EW'(ONE)))
        else $error("Matrix element beyond unit range.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("Accepted beat did not enter the pipeline.");
`endif

endmodule
